// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion, checked at every edge including reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/lrtc_pkg.sv
// ----------------------------------------------------------------------------
// lrtc_pkg
// Types and constants of the row-band tile cache lookup.
// ----------------------------------------------------------------------------
`default_nettype none
package lrtc_pkg;

  localparam int IDX_W   = 6;   // slot index, covers up to 64 slots
  localparam int STAMP_W = 31;
  localparam int ROW_W   = 20;
  localparam int DIM_W   = 21;
  localparam int CFG_W   = 3;

  localparam logic [STAMP_W-1:0] STAMP_RESTART_LIMIT = 31'h4000_0000;

  localparam logic [CFG_W-1:0] CFG_IMAGE_LINES   = 3'd0;
  localparam logic [CFG_W-1:0] CFG_IMAGE_SAMPLES = 3'd1;
  localparam logic [CFG_W-1:0] CFG_TILE_ROWS     = 3'd2;
  localparam logic [CFG_W-1:0] CFG_PIXEL_BYTES   = 3'd3;
  localparam logic [CFG_W-1:0] CFG_SLOTS_ALLOWED = 3'd4;

  // Search packet handed from cell to cell.
  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   found_idx;
    logic [ROW_W-1:0]   found_rs;
    logic               have_min;
    logic [IDX_W-1:0]   min_idx;
    logic [STAMP_W-1:0] min_stamp;
  } scan_t;

  // Update command broadcast to all cells.
  typedef struct packed {
    logic               wr;
    logic               clr;
    logic [IDX_W-1:0]   idx;
    logic [ROW_W-1:0]   row_start;
    logic [STAMP_W-1:0] stamp;
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/lrtc_req_if.sv
// ----------------------------------------------------------------------------
// lrtc_req_if
// Request channel: one pixel coordinate per beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface lrtc_req_if;
  logic        valid;
  logic        ready;
  logic [20:0] line_index;
  logic [20:0] sample_index;
  modport source (output valid, line_index, sample_index, input ready);
  modport sink   (input valid, line_index, sample_index, output ready);
endinterface
`default_nettype wire

// File: rtl/lrtc_rsp_if.sv
// ----------------------------------------------------------------------------
// lrtc_rsp_if
// Result channel: one lookup result per beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface lrtc_rsp_if;
  logic        valid;
  logic        ready;
  logic        outside;
  logic        hit;
  logic [4:0]  slot;
  logic [31:0] byte_offset;
  logic [19:0] load_row_start;
  logic [20:0] load_row_count;
  modport source (output valid, outside, hit, slot, byte_offset, load_row_start,
                  load_row_count, input ready);
  modport sink   (input valid, outside, hit, slot, byte_offset, load_row_start,
                  load_row_count, output ready);
endinterface
`default_nettype wire

// File: rtl/lrtc_cfg_if.sv
// ----------------------------------------------------------------------------
// lrtc_cfg_if
// Configuration write channel: register index and data per beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface lrtc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [20:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/lrtc_div.sv
// ----------------------------------------------------------------------------
// lrtc_div
// Restoring divider, one quotient bit per cycle; yields the remainder.
// ----------------------------------------------------------------------------
`default_nettype none
module lrtc_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [19:0] dividend,
  input  wire logic [20:0] divisor,
  output logic             done,
  output logic [19:0]      rem
);
  localparam int STEPS = 20;
  localparam int CNT_W = $clog2(STEPS);

  logic [20:0]      acc;
  logic [19:0]      dvd;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [21:0]      trial;
  logic [20:0]      acc_next;

  always_comb begin
    trial = {acc, dvd[19]};
    if (trial >= {1'b0, divisor}) begin
      acc_next = 21'(trial - {1'b0, divisor});
    end else begin
      acc_next = trial[20:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      acc  <= '0;
      dvd  <= dividend;
    end else if (busy) begin
      // shift in next dividend bit
      acc <= acc_next;
      dvd <= {dvd[18:0], 1'b0};
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign rem = acc[19:0];
endmodule
`default_nettype wire

// File: rtl/lrtc_cell.sv
// ----------------------------------------------------------------------------
// lrtc_cell
// One tile slot: holds valid, band start and stamp; checks the passing
// search packet and hands it on.
// ----------------------------------------------------------------------------
`default_nettype none
module lrtc_cell #(
  parameter int IDX = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [19:0]           line,
  input  wire logic [20:0]           band,
  input  wire lrtc_pkg::cmd_t        cmd,
  input  wire lrtc_pkg::scan_t       scan_in,
  output lrtc_pkg::scan_t            scan_out
);
  logic                           valid;
  logic [lrtc_pkg::ROW_W-1:0]     row_start;
  logic [lrtc_pkg::STAMP_W-1:0]   stamp;
  logic                           sel;
  logic                           hit_here;
  lrtc_pkg::scan_t                scan_next;

  assign sel = cmd.wr && (cmd.idx == lrtc_pkg::IDX_W'(IDX));
  assign hit_here = valid && (line >= row_start) &&
                    ({2'b00, line} < ({2'b00, row_start} + {1'b0, band}));

  always_comb begin
    scan_next = scan_in;
    if (!scan_in.found && hit_here) begin
      scan_next.found     = 1'b1;
      scan_next.found_idx = lrtc_pkg::IDX_W'(IDX);
      scan_next.found_rs  = row_start;
    end
    if (valid && (!scan_in.have_min || stamp < scan_in.min_stamp)) begin
      scan_next.have_min  = 1'b1;
      scan_next.min_idx   = lrtc_pkg::IDX_W'(IDX);
      scan_next.min_stamp = stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      stamp    <= '0;
      scan_out <= '0;
    end else begin
      scan_out <= scan_next;
      if (sel) begin
        valid <= 1'b1;
        stamp <= cmd.stamp;
      end else if (cmd.clr) begin
        stamp <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      row_start <= cmd.row_start;
    end
  end
endmodule
`default_nettype wire

// File: rtl/lru_row_tile_cache_lookup_core.sv
// ----------------------------------------------------------------------------
// lru_row_tile_cache_lookup_core
// Row-band tile cache lookup with least recently used replacement.
// ----------------------------------------------------------------------------
// One request at a time. A coordinate outside the image skips the scan and
// goes straight to the final state, which loads the result register. Any
// other request passes through the scan state: a search packet walks down
// the chain of slot cells, one cell per cycle, collecting the first matching
// band and the oldest stamp, while a bit-serial divider finds, in parallel,
// the band start. The update state then writes the cells, the multiply, add
// and scale states form the byte offset (scale by pixel size), and the final
// state loads the result register. The result register frees the block to
// take the next request while the result still waits on the sink; a result
// still held there stalls the next result load until the sink takes it.
// Configuration is accepted at any time but is meant for an idle block.
`default_nettype none
module lru_row_tile_cache_lookup_core #(
  parameter int TILE_SLOTS = 24
) (
  input  wire logic   clk,
  input  wire logic   rst,
  lrtc_req_if.sink    req,
  lrtc_rsp_if.source  rsp,
  lrtc_cfg_if.sink    cfg
);
  localparam int CNT_W = $clog2(TILE_SLOTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_SCALE = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  // configuration registers
  logic [20:0] image_lines;
  logic [20:0] image_samples;
  logic [20:0] tile_rows;
  logic [3:0]  pixel_bytes;
  logic [4:0]  slots_allowed;

  // control
  logic [2:0]                   state;
  logic [CNT_W-1:0]             scan_cnt;
  logic [lrtc_pkg::STAMP_W-1:0] access_counter;
  logic [CNT_W-1:0]             slots_in_use;
  logic                         slots_full;

  // request and work registers
  logic        outside;
  logic [19:0] line;
  logic [19:0] samp;
  logic        hit;
  logic [lrtc_pkg::IDX_W-1:0] spot;
  logic [19:0] start;
  logic [20:0] count;
  logic [40:0] prod;
  logic [41:0] sum;
  logic [31:0] offset;

  logic [20:0]      band;
  logic [CNT_W-1:0] allowed;
  logic             accept;
  logic             in_out;
  logic             div_done;
  logic [19:0]      div_rem;
  logic             rsp_free;

  lrtc_pkg::scan_t chain [TILE_SLOTS+1];
  lrtc_pkg::scan_t last;
  lrtc_pkg::cmd_t  cmd;

  // update-cycle decisions
  logic [lrtc_pkg::IDX_W-1:0]   spot_next;
  logic [19:0]                  start_next;
  logic [20:0]                  count_next;
  logic [lrtc_pkg::STAMP_W-1:0] counter_next;
  logic [CNT_W-1:0]             in_use_next;
  logic                         full_next;
  logic [45:0]                  scaled;

  assign band    = (tile_rows == '0) ? 21'd1 : tile_rows;
  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign rsp_free  = !rsp.valid || rsp.ready;
  assign last      = chain[TILE_SLOTS];

  always_comb begin
    if (slots_allowed == '0) begin
      allowed = CNT_W'(1);
    end else if ({2'b00, slots_allowed} > 7'(TILE_SLOTS)) begin
      allowed = CNT_W'(TILE_SLOTS);
    end else begin
      allowed = CNT_W'(slots_allowed);
    end
  end

  // outside test on the incoming beat
  assign in_out = req.line_index[20] || req.sample_index[20] ||
                  ({1'b0, req.line_index[19:0]} >= image_lines) ||
                  ({1'b0, req.sample_index[19:0]} >= image_samples);

  lrtc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && !in_out),
    .dividend (req.line_index[19:0]),
    .divisor  (band),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign chain[0] = '0;

  for (genvar g = 0; g < TILE_SLOTS; g++) begin : g_cell
    lrtc_cell #(.IDX(g)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .line     (line),
      .band     (band),
      .cmd      (cmd),
      .scan_in  (chain[g]),
      .scan_out (chain[g+1])
    );
  end

  // Decide slot, stamp and band on the update cycle.
  always_comb begin
    cmd          = '0;
    spot_next    = last.found_idx;
    start_next   = last.found_rs;
    count_next   = '0;
    counter_next = access_counter + 1'b1;
    in_use_next  = slots_in_use;
    full_next    = slots_full;
    cmd.stamp    = access_counter;
    if (last.found) begin
      // restart stamps once the counter runs past the limit
      if (access_counter > lrtc_pkg::STAMP_RESTART_LIMIT) begin
        cmd.clr      = 1'b1;
        cmd.stamp    = lrtc_pkg::STAMP_W'(1);
        counter_next = lrtc_pkg::STAMP_W'(2);
      end
    end else begin
      start_next = 20'(line - div_rem);
      if (!slots_full && slots_in_use < allowed) begin
        spot_next   = lrtc_pkg::IDX_W'(slots_in_use);
        in_use_next = slots_in_use + 1'b1;
        if (in_use_next == CNT_W'(TILE_SLOTS)) begin
          full_next = 1'b1;
        end
      end else begin
        full_next = 1'b1;
        spot_next = last.min_idx;
      end
      if (({2'b00, start_next} + {1'b0, band}) > {1'b0, image_lines}) begin
        count_next = 21'(image_lines - {1'b0, start_next});
      end else begin
        count_next = band;
      end
    end
    cmd.idx       = spot_next;
    cmd.row_start = start_next;
    cmd.wr        = (state == S_UPD);
    if (state != S_UPD) begin
      cmd.clr = 1'b0;
    end
  end

  assign scaled = sum * pixel_bytes;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_lines   <= 21'd1024;
      image_samples <= 21'd1024;
      tile_rows     <= 21'd64;
      pixel_bytes   <= 4'd4;
      slots_allowed <= 5'd24;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        lrtc_pkg::CFG_IMAGE_LINES:   image_lines   <= cfg.data;
        lrtc_pkg::CFG_IMAGE_SAMPLES: image_samples <= cfg.data;
        lrtc_pkg::CFG_TILE_ROWS:     tile_rows     <= cfg.data;
        lrtc_pkg::CFG_PIXEL_BYTES:   pixel_bytes   <= cfg.data[3:0];
        lrtc_pkg::CFG_SLOTS_ALLOWED: slots_allowed <= cfg.data[4:0];
        default: ;
      endcase
    end
  end

  // sequencer and cache state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      scan_cnt       <= '0;
      access_counter <= '0;
      slots_in_use   <= '0;
      slots_full     <= 1'b0;
      rsp.valid      <= 1'b0;
    end else begin
      // load a new result beat, or drop the one the sink took
      if (state == S_FIN && rsp_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          scan_cnt <= '0;
          if (accept) begin
            state <= in_out ? S_FIN : S_SCAN;
          end
        end
        S_SCAN: begin
          // wait for the packet to leave the last cell and the divider
          if (scan_cnt != CNT_W'(TILE_SLOTS)) begin
            scan_cnt <= scan_cnt + 1'b1;
          end else if (div_done) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          access_counter <= counter_next;
          slots_in_use   <= in_use_next;
          slots_full     <= full_next;
          state          <= S_MUL;
        end
        S_MUL:   state <= S_ADD;
        S_ADD:   state <= S_SCALE;
        S_SCALE: state <= S_FIN;
        S_FIN: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      outside <= in_out;
      line    <= req.line_index[19:0];
      samp    <= req.sample_index[19:0];
    end
    if (state == S_UPD) begin
      hit   <= last.found;
      spot  <= spot_next;
      start <= start_next;
      count <= count_next;
    end
    if (state == S_MUL) begin
      prod <= 20'(line - start) * image_samples;
    end
    if (state == S_ADD) begin
      sum <= {1'b0, prod} + {22'd0, samp};
    end
    if (state == S_SCALE) begin
      offset <= (scaled[45:32] != '0) ? 32'hFFFF_FFFF : scaled[31:0];
    end
    if (state == S_FIN && rsp_free) begin
      rsp.outside        <= outside;
      rsp.hit            <= !outside && hit;
      rsp.slot           <= outside ? 5'd0 : spot[4:0];
      rsp.byte_offset    <= outside ? 32'd0 : offset;
      rsp.load_row_start <= (outside || hit) ? 20'd0 : start;
      rsp.load_row_count <= (outside || hit) ? 21'd0 : count;
    end
  end
endmodule
`default_nettype wire

// File: rtl/lrtc_chk.sv
// ----------------------------------------------------------------------------
// lrtc_chk
// Port-level checks of the tile cache lookup result stream.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module lrtc_chk #(
  parameter int TILE_SLOTS = 24
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic        outside,
  input wire logic        hit,
  input wire logic [4:0]  slot,
  input wire logic [31:0] byte_offset,
  input wire logic [19:0] load_row_start,
  input wire logic [20:0] load_row_count
);
  `ASSERT_RST(a_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(byte_offset) && $stable(slot), "result changed while stalled")
  `ASSERT_RST(a_outside, clk, rst, rsp_valid && outside |-> !hit && slot == 5'd0 && byte_offset == 32'd0 && load_row_count == 21'd0, "outside result not cleared")
  `ASSERT_RST(a_hit, clk, rst, rsp_valid && hit |-> load_row_start == 20'd0 && load_row_count == 21'd0, "hit reports a load")
  `ASSERT_RST(a_miss, clk, rst, rsp_valid && !outside && !hit |-> load_row_count != 21'd0 && slot < TILE_SLOTS, "miss without rows or bad slot")
endmodule

bind lru_row_tile_cache_lookup_core lrtc_chk #(.TILE_SLOTS(TILE_SLOTS)) u_chk (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .outside        (rsp.outside),
  .hit            (rsp.hit),
  .slot           (rsp.slot),
  .byte_offset    (rsp.byte_offset),
  .load_row_start (rsp.load_row_start),
  .load_row_count (rsp.load_row_count)
);
`default_nettype wire

// File: tb/sv/lru_row_tile_cache_lookup_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_row_tile_cache_lookup_core_tb
// Self-checking bench for the row-band tile cache lookup. A directed table
// covers the image edges and the first fills. Random phases then run under
// several register settings, the extremes among them. Every result beat is
// checked field by field against its typed row or a built-in model of the slot store.
// ----------------------------------------------------------------------------
module lru_row_tile_cache_lookup_core_tb;

  localparam int SLOTS       = 24;
  localparam int PHASE_ITEMS = 158;
  localparam int NUM_PHASES  = 11;

  typedef struct packed {
    bit        outside;
    bit        hit;
    bit [4:0]  slot;
    bit [31:0] byte_offset;
    bit [19:0] load_row_start;
    bit [20:0] load_row_count;
  } lookup_t;

  typedef struct {
    bit [20:0] line_index;
    bit [20:0] sample_index;
    bit        typed;
    lookup_t   result;
  } probe_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lrtc_req_if req ();
  lrtc_rsp_if rsp ();
  lrtc_cfg_if cfg ();

  lru_row_tile_cache_lookup_core #(.TILE_SLOTS(SLOTS)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model copy of the registers and of the slot store.
  bit [20:0] img_lines, img_samples, band_rows;
  bit [3:0]  px_bytes;
  bit [4:0]  slot_limit;
  bit        sv_valid [SLOTS];
  bit [19:0] sv_start [SLOTS];
  bit [30:0] sv_stamp [SLOTS];
  bit [30:0] use_count;
  int        n_used;
  bit        evicting;

  lookup_t pending_q[$];
  int      n_errors  = 0;
  int      n_results = 0;
  int      n_hits    = 0;
  int      n_misses  = 0;
  int      n_outside = 0;
  bit      calm      = 1'b0;   // no idling on either side
  bit      hold_sink = 1'b0;   // long back-pressure request

  function automatic lookup_t cache_lookup(bit [20:0] li, bit [20:0] si);
    lookup_t r;
    longint  ln, sn, band, start, cnt, off;
    int      allowed, spot, i;
    bit      found;
    bit [30:0] least;
    r = '0;
    ln = longint'(signed'(li));
    sn = longint'(signed'(si));
    band = (band_rows == 0) ? 1 : band_rows;
    allowed = (slot_limit < 1) ? 1 : ((slot_limit > SLOTS) ? SLOTS : slot_limit);
    if (ln < 0 || sn < 0 || ln >= img_lines || sn >= img_samples) begin
      r.outside = 1'b1;
      return r;
    end
    found = 1'b0;
    spot = 0;
    cnt = 0;
    for (i = 0; i < n_used; i++) begin
      if (!found && sv_valid[i] && ln >= sv_start[i] && ln < sv_start[i] + band) begin
        found = 1'b1;
        spot = i;
      end
    end
    if (found) begin
      // Restart the stamps once the counter has run past the limit.
      if (use_count > lrtc_pkg::STAMP_RESTART_LIMIT) begin
        for (i = 0; i < n_used; i++) sv_stamp[i] = '0;
        use_count = 31'd1;
      end
      sv_stamp[spot] = use_count;
      use_count++;
      start = sv_start[spot];
    end else begin
      if (!evicting) begin
        if (n_used < allowed) begin
          spot = n_used;
          n_used++;
        end else begin
          evicting = 1'b1;
        end
      end
      if (evicting) begin
        // Oldest stamp, lowest index on a tie.
        least = sv_stamp[0];
        spot = 0;
        for (i = 0; i < n_used; i++) begin
          if (sv_stamp[i] < least) begin
            least = sv_stamp[i];
            spot = i;
          end
        end
      end
      if (!evicting && n_used == SLOTS) evicting = 1'b1;
      start = (ln / band) * band;
      sv_valid[spot] = 1'b1;
      sv_start[spot] = start[19:0];
      sv_stamp[spot] = use_count;
      use_count++;
      cnt = (start + band > img_lines) ? img_lines - start : band;
    end
    off = ((ln - start) * img_samples + sn) * px_bytes;
    if (off > 64'hFFFF_FFFF) off = 64'hFFFF_FFFF;
    r.hit = found;
    r.slot = spot[4:0];
    r.byte_offset = off[31:0];
    r.load_row_start = found ? 20'd0 : start[19:0];
    r.load_row_count = found ? 21'd0 : cnt[20:0];
    return r;
  endfunction

  task automatic report_field(string name, longint e, longint a);
    if (e != a) begin
      $display("[%0t] mismatch on %s: expected %0d, actual %0d", $realtime, name, e, a);
      n_errors++;
    end
  endtask

  // Result side: sample at the rising edge, compare against the oldest entry.
  always @(posedge clk) begin
    lookup_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_q.size() == 0) begin
        $display("[%0t] unexpected result beat: expected none, actual slot %0d",
                 $realtime, rsp.slot);
        n_errors++;
      end else begin
        e = pending_q.pop_front();
        report_field("outside", e.outside, rsp.outside);
        report_field("hit", e.hit, rsp.hit);
        report_field("slot", e.slot, rsp.slot);
        report_field("byte_offset", e.byte_offset, rsp.byte_offset);
        report_field("load_row_start", e.load_row_start, rsp.load_row_start);
        report_field("load_row_count", e.load_row_count, rsp.load_row_count);
        n_results++;
        if (e.outside) n_outside++;
        else if (e.hit) n_hits++;
        else n_misses++;
      end
    end
  end

  // Result side ready: random stall bursts, plus one long hold-off on request.
  initial begin
    int k;
    rsp.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_sink) begin
        rsp.ready = 1'b0;
        for (k = 0; k < 300; k++) @(negedge clk);
        hold_sink = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rsp.ready = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        rsp.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // Drive one beat from the falling edge; return at the falling edge after it is taken, or after a random idle gap.
  task automatic send_lookup(bit [20:0] li, bit [20:0] si, bit typed, lookup_t typed_res);
    lookup_t p;
    req.valid = 1'b1;
    req.line_index = li;
    req.sample_index = si;
    do @(posedge clk); while (!req.ready);
    p = cache_lookup(li, si);
    pending_q.push_back(typed ? typed_res : p);
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [lrtc_pkg::CFG_W-1:0] idx, bit [20:0] value);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data = value;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      lrtc_pkg::CFG_IMAGE_LINES:   img_lines = value;
      lrtc_pkg::CFG_IMAGE_SAMPLES: img_samples = value;
      lrtc_pkg::CFG_TILE_ROWS:     band_rows = value;
      lrtc_pkg::CFG_PIXEL_BYTES:   px_bytes = value[3:0];
      lrtc_pkg::CFG_SLOTS_ALLOWED: slot_limit = value[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // Hold until every result is in, then let the pipeline drain.
  task automatic wait_idle();
    req.valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (SLOTS + 10) @(negedge clk);
  endtask

  // Mostly lines from a few bands around the slot limit so hits, fills and
  // evictions all occur; the rest are raw 21-bit coordinates.
  task automatic send_random();
    int unsigned band, nb, ln, sn;
    if ($urandom_range(0, 99) < 12) begin
      send_lookup(21'($urandom_range(0, 21'h1FFFFF)), 21'($urandom_range(0, 21'h1FFFFF)),
                  1'b0, '0);
      return;
    end
    band = (band_rows == 0) ? 1 : band_rows;
    nb = img_lines / band;
    if (nb > slot_limit + 3) nb = slot_limit + 3;
    ln = $urandom_range(0, nb) * band + $urandom_range(0, band - 1);
    if (ln >= img_lines) ln = ln % img_lines;
    sn = $urandom_range(0, 3) == 0 ? img_samples - 1 : $urandom_range(0, img_samples - 1);
    send_lookup(ln[20:0], sn[20:0], 1'b0, '0);
  endtask

  probe_t probes[$];

  initial begin
    int ph, n;
    bit [20:0] pcfg [5];
    req.valid = 1'b0;
    req.line_index = '0;
    req.sample_index = '0;
    cfg.valid = 1'b0;
    cfg.index = lrtc_pkg::CFG_IMAGE_LINES;
    cfg.data = '0;
    img_lines = 21'd1024;
    img_samples = 21'd1024;
    band_rows = 21'd64;
    px_bytes = 4'd4;
    slot_limit = 5'd24;
    foreach (sv_valid[i]) begin
      sv_valid[i] = 1'b0;
      sv_start[i] = '0;
      sv_stamp[i] = '0;
    end
    use_count = '0;
    n_used = 0;
    evicting = 1'b0;

    // Directed table under reset settings; typed rows are read off directly.
    probes = '{
      '{21'h1FFFFF, 21'd0,      1'b1, lookup_t'{1'b1, 1'b0, 5'd0, 32'd0, 20'd0, 21'd0}},
      '{21'd0,      21'h1FFFFF, 1'b1, lookup_t'{1'b1, 1'b0, 5'd0, 32'd0, 20'd0, 21'd0}},
      '{21'd1024,   21'd0,      1'b1, lookup_t'{1'b1, 1'b0, 5'd0, 32'd0, 20'd0, 21'd0}},
      '{21'd0,      21'd1024,   1'b1, lookup_t'{1'b1, 1'b0, 5'd0, 32'd0, 20'd0, 21'd0}},
      '{21'h0FFFFF, 21'h0FFFFF, 1'b1, lookup_t'{1'b1, 1'b0, 5'd0, 32'd0, 20'd0, 21'd0}},
      '{21'h100000, 21'h100000, 1'b1, lookup_t'{1'b1, 1'b0, 5'd0, 32'd0, 20'd0, 21'd0}},
      '{21'd0,      21'd0,      1'b1, lookup_t'{1'b0, 1'b0, 5'd0, 32'd0, 20'd0, 21'd64}},
      '{21'd1023,   21'd1023,   1'b1, lookup_t'{1'b0, 1'b0, 5'd1, 32'd262140, 20'd960, 21'd64}},
      '{21'd5,      21'd3,      1'b1, lookup_t'{1'b0, 1'b1, 5'd0, 32'd20492, 20'd0, 21'd0}},
      '{21'd63,     21'd0,      1'b0, '0},
      '{21'd64,     21'd1,      1'b0, '0},
      '{21'd960,    21'd7,      1'b0, '0},
      '{21'd500,    21'd500,    1'b0, '0}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    foreach (probes[i])
      send_lookup(probes[i].line_index, probes[i].sample_index, probes[i].typed,
                  probes[i].result);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: pcfg = '{21'h100000, 21'h100000, 21'h100000, 21'd15, 21'd1};
        1: pcfg = '{21'd1, 21'd1, 21'd1, 21'd0, 21'd0};
        2: pcfg = '{21'd700, 21'd900, 21'd0, 21'd13, 21'd31};
        3: pcfg = '{21'h100000, 21'h0FFFFF, 21'd1, 21'd12, 21'd24};
        default: pcfg = '{21'($urandom_range(1, 400)), 21'($urandom_range(1, 400)),
                          21'($urandom_range(1, 40)), 21'($urandom_range(0, 15)),
                          21'($urandom_range(0, 31))};
      endcase
      for (n = 0; n < 5; n++) write_reg(n[lrtc_pkg::CFG_W-1:0], pcfg[n]);
      // Fill the block against a stalled sink once.
      if (ph == 5) hold_sink = 1'b1;
      calm = (ph == NUM_PHASES - 1);
      for (n = 0; n < PHASE_ITEMS; n++) send_random();
    end

    req.valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (SLOTS + 10) @(negedge clk);
    $display("Covered %0d results: %0d hits, %0d misses, %0d outside, over %0d settings.",
             n_results, n_hits, n_misses, n_outside, NUM_PHASES + 1);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding.", pending_q.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: lru_row_tile_cache_lookup_core.f
+incdir+rtl
rtl/lrtc_pkg.sv
rtl/lrtc_req_if.sv
rtl/lrtc_rsp_if.sv
rtl/lrtc_cfg_if.sv
rtl/lrtc_div.sv
rtl/lrtc_cell.sv
rtl/lru_row_tile_cache_lookup_core.sv
rtl/lrtc_chk.sv
tb/sv/lru_row_tile_cache_lookup_core_tb.sv
